### sv/multilevel_hysteresis_alarm_stager_core_defines.svh
// Assertion macros shared by the alarm stager checker.
`ifndef MULTILEVEL_HYSTERESIS_ALARM_STAGER_CORE_DEFINES_SVH
`define MULTILEVEL_HYSTERESIS_ALARM_STAGER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MHAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MHAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mhas_pkg.sv
// Types and constants of the multilevel hysteresis alarm stager.
package mhas_pkg;

  localparam int unsigned LevelW = 10;
  localparam int unsigned AngleW = 8;
  localparam int unsigned DepthW = 12;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [2:0] {
    STAGE_CALM     = 3'd0,
    STAGE_PREWARN  = 3'd1,
    STAGE_CLEAR    = 3'd2,
    STAGE_CRITICAL = 3'd3,
    STAGE_FAULT    = 3'd4
  } stage_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PREWARN_LEVEL = 3'd0,
    CFG_CLEAR_LEVEL   = 3'd1,
    CFG_DANGER_LEVEL  = 3'd2,
    CFG_HYST_MARGIN   = 3'd3,
    CFG_CLOSED_ANGLE  = 3'd4,
    CFG_PREWARN_ANGLE = 3'd5,
    CFG_CLEAR_ANGLE   = 3'd6,
    CFG_DANGER_ANGLE  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [LevelW-1:0] prewarn_level;
    logic [LevelW-1:0] clear_level;
    logic [LevelW-1:0] danger_level;
    logic [LevelW-1:0] hysteresis_margin;
    logic [AngleW-1:0] closed_angle;
    logic [AngleW-1:0] prewarn_angle;
    logic [AngleW-1:0] clear_angle;
    logic [AngleW-1:0] danger_angle;
  } cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] fill_level;
    logic              first_sensor_ok;
    logic              second_sensor_ok;
    logic              manual_override;
    logic [DepthW-1:0] water_depth;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        alert_stage;
    logic              stage_changed;
    logic              gate_cmd_valid;
    logic [AngleW-1:0] gate_angle;
    logic              alert_send;
    logic [LevelW-1:0] alert_fill;
    logic [DepthW-1:0] alert_depth;
  } out_item_t;

endpackage

### sv/mhas_cfg.sv
// Configuration register file: thresholds, hysteresis margin and gate angles.
module mhas_cfg import mhas_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_index_i,
  input  logic [LevelW-1:0]  wr_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Decode the write index; angle registers take the low byte
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_index_i))
        CFG_PREWARN_LEVEL: cfg_d.prewarn_level     = wr_data_i;
        CFG_CLEAR_LEVEL:   cfg_d.clear_level       = wr_data_i;
        CFG_DANGER_LEVEL:  cfg_d.danger_level      = wr_data_i;
        CFG_HYST_MARGIN:   cfg_d.hysteresis_margin = wr_data_i;
        CFG_CLOSED_ANGLE:  cfg_d.closed_angle      = wr_data_i[AngleW-1:0];
        CFG_PREWARN_ANGLE: cfg_d.prewarn_angle     = wr_data_i[AngleW-1:0];
        CFG_CLEAR_ANGLE:   cfg_d.clear_angle       = wr_data_i[AngleW-1:0];
        CFG_DANGER_ANGLE:  cfg_d.danger_angle      = wr_data_i[AngleW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  // Hold the registers, loading the power-up defaults on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prewarn_level     <= LevelW'(700);
      cfg_q.clear_level       <= LevelW'(780);
      cfg_q.danger_level      <= LevelW'(850);
      cfg_q.hysteresis_margin <= LevelW'(30);
      cfg_q.closed_angle      <= AngleW'(0);
      cfg_q.prewarn_angle     <= AngleW'(45);
      cfg_q.clear_angle       <= AngleW'(90);
      cfg_q.danger_angle      <= AngleW'(180);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/mhas_stage.sv
// Next-stage decision and result formation for one telemetry item.
module mhas_stage import mhas_pkg::*; (
  input  stage_e    stage_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output stage_e    stage_o,
  output out_item_t result_o
);

  logic [LevelW-1:0] fall_prewarn;
  logic [LevelW-1:0] fall_clear;
  logic [LevelW-1:0] fall_danger;
  logic              sensors_lost;
  stage_e            rise_st;
  stage_e            nxt;
  logic              changed;
  logic              gate;
  logic [AngleW-1:0] angle;

  // Falling points: threshold less margin, floored at zero
  always_comb begin
    fall_prewarn = (cfg_i.prewarn_level > cfg_i.hysteresis_margin) ?
                   cfg_i.prewarn_level - cfg_i.hysteresis_margin : '0;
    fall_clear   = (cfg_i.clear_level > cfg_i.hysteresis_margin) ?
                   cfg_i.clear_level - cfg_i.hysteresis_margin : '0;
    fall_danger  = (cfg_i.danger_level > cfg_i.hysteresis_margin) ?
                   cfg_i.danger_level - cfg_i.hysteresis_margin : '0;
  end

  // Highest rising threshold reached, else keep the current stage
  always_comb begin
    if (item_i.fill_level >= cfg_i.danger_level) begin
      rise_st = STAGE_CRITICAL;
    end else if (item_i.fill_level >= cfg_i.clear_level) begin
      rise_st = STAGE_CLEAR;
    end else if (item_i.fill_level >= cfg_i.prewarn_level) begin
      rise_st = STAGE_PREWARN;
    end else begin
      rise_st = stage_i;
    end
  end

  // Choose the next stage; a fall drops one step only
  always_comb begin
    sensors_lost = !item_i.first_sensor_ok && !item_i.second_sensor_ok;
    nxt = stage_i;
    if (sensors_lost) begin
      nxt = STAGE_FAULT;
    end else begin
      case (stage_i)
        STAGE_PREWARN: begin
          nxt = rise_st;
          if (rise_st == STAGE_PREWARN && item_i.fill_level < fall_prewarn) begin
            nxt = STAGE_CALM;
          end
        end
        STAGE_CLEAR: begin
          if (item_i.fill_level >= cfg_i.danger_level) begin
            nxt = STAGE_CRITICAL;
          end else if (item_i.fill_level < fall_clear) begin
            nxt = STAGE_PREWARN;
          end
        end
        STAGE_CRITICAL: begin
          if (item_i.fill_level < fall_danger) begin
            nxt = STAGE_CLEAR;
          end
        end
        STAGE_FAULT: nxt = STAGE_CALM;
        default:     nxt = rise_st;
      endcase
    end
  end

  // Gate angle of the new stage
  always_comb begin
    case (nxt)
      STAGE_PREWARN:  angle = cfg_i.prewarn_angle;
      STAGE_CLEAR:    angle = cfg_i.clear_angle;
      STAGE_CRITICAL: angle = cfg_i.danger_angle;
      STAGE_FAULT:    angle = cfg_i.prewarn_angle;
      default:        angle = cfg_i.closed_angle;
    endcase
  end

  // Build the result; fields not flagged read as zero
  always_comb begin
    changed = (nxt != stage_i);
    gate    = changed && !sensors_lost && !item_i.manual_override;
    result_o.alert_stage    = nxt;
    result_o.stage_changed  = changed;
    result_o.gate_cmd_valid = gate;
    result_o.gate_angle     = gate ? angle : '0;
    result_o.alert_send     = changed;
    result_o.alert_fill     = changed ? item_i.fill_level : '0;
    result_o.alert_depth    = changed ? item_i.water_depth : '0;
  end

  assign stage_o = nxt;

endmodule

### sv/multilevel_hysteresis_alarm_stager_core.sv
// Top level of the multilevel hysteresis alarm stager.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i/in_ready_o   in_data_i  (in_item_t)
//   out       output     out_valid_o/out_ready_i out_data_o (out_item_t)
//   cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle sustained while results are taken; an accepted item is
// held in the input register, then moves into the result register when it advances.
// The stage register updates as an item moves into the result register.
// Reset returns the stage to calm, clears both valid flags and loads the cfg defaults.
// A stalled result holds the pipeline; in_ready_o drops only when both
// registers are full and the result is not taken. cfg is always ready.
module multilevel_hysteresis_alarm_stager_core import mhas_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [LevelW-1:0]  cfg_data_i
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  out_item_t out_d;
  logic      out_valid_q;
  stage_e    stage_q;
  stage_e    stage_d;
  logic      advance;

  assign cfg_ready_o = 1'b1;

  mhas_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  mhas_stage u_stage (
    .stage_i  (stage_q),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .stage_o  (stage_d),
    .result_o (out_d)
  );

  // Advance when an item waits and the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Result register and stage update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      stage_q     <= STAGE_CALM;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      stage_q     <= stage_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sv/mhas_checker.sv
// Port-level checker for the alarm stager, bound to the top level.
`include "multilevel_hysteresis_alarm_stager_core_defines.svh"

module mhas_checker import mhas_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // A stalled result stays put
  `MHAS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result changed while stalled")

  // Every stage change raises an alert, and only a change does
  `MHAS_ASSERT_NOW(a_alert_on_change, out_valid_o, out_data_o.stage_changed == out_data_o.alert_send, "alert flag differs from stage change")

  // A gate command only accompanies a stage change
  `MHAS_ASSERT_NOW(a_gate_needs_change, out_valid_o && out_data_o.gate_cmd_valid, out_data_o.stage_changed, "gate command without stage change")

  // Entering sensor fault never moves the gate
  `MHAS_ASSERT_NOW(a_fault_no_gate, out_valid_o && out_data_o.alert_stage == STAGE_FAULT, !out_data_o.gate_cmd_valid, "gate command in fault stage")

  // No gate command means a zero angle field
  `MHAS_ASSERT_NOW(a_angle_zero, out_valid_o && !out_data_o.gate_cmd_valid, out_data_o.gate_angle == '0, "angle set without gate command")

endmodule

bind multilevel_hysteresis_alarm_stager_core mhas_checker u_mhas_checker (.*);
